>>> sv/twct_pkg.sv
// ----------------------------------------------------------------------------
// twct_pkg
// Shared types and constants of the timing wheel callout table: field widths,
// action codes, the command passed from front to back, the result item and
// the back-end state encoding.
// ----------------------------------------------------------------------------
package twct_pkg;

    // Port field widths
    localparam int ACTION_W   = 2;
    localparam int ENTRY_ID_W = 4;
    localparam int DELAY_W    = 16;

    // Uptime and expiry width, and the step counter of the bucket modulo
    localparam int TIME_W    = 32;
    localparam int MOD_CNT_W = 1;

    // Default table geometry
    localparam int NUM_ENTRIES_DEF = 16;
    localparam int NUM_BUCKETS_DEF = 5;

    // Queue depths
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int RES_FIFO_DEPTH = 2;

    // Action codes on the input port
    localparam logic [ACTION_W-1:0] ACT_ARM  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_STOP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_TICK = 2'd2;

    // Command kinds after classification
    typedef enum logic [1:0] {
        CMD_ARM,
        CMD_STOP,
        CMD_TICK
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [ENTRY_ID_W-1:0]   entry_id;
        logic [DELAY_W-1:0]      delay;
    } cmd_t;

    typedef struct packed {
        logic [ENTRY_ID_W-1:0]   fired_entry;
        logic                    overdue;
        logic                    last;
    } result_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        B_IDLE,
        B_MOD,
        B_SCAN,
        B_LAST
    } back_state_t;

endpackage

>>> sv/twct_fifo.sv
// ----------------------------------------------------------------------------
// twct_fifo
// Small synchronous queue with push/full and pop/empty sides; the head entry
// is shown on rdata while empty is low.
// ----------------------------------------------------------------------------
module twct_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed data
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

>>> sv/twct_ram.sv
// ----------------------------------------------------------------------------
// twct_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module twct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    assign rdata = rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

endmodule

>>> sv/twct_front.sv
// ----------------------------------------------------------------------------
// twct_front
// Input side: accept items, drop unused action codes and entries outside the
// table, and queue the remaining commands for the back end.
// ----------------------------------------------------------------------------
module twct_front #(
    parameter int NUM_ENTRIES = twct_pkg::NUM_ENTRIES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic [twct_pkg::ACTION_W-1:0]       action,
    input  logic [twct_pkg::ENTRY_ID_W-1:0]     entry_id,
    input  logic [twct_pkg::DELAY_W-1:0]        delay,
    output logic                                full,
    output twct_pkg::cmd_t                      cmd,
    output logic                                cmd_empty,
    input  logic                                cmd_pop
);

    localparam int CMD_W = $bits(twct_pkg::cmd_t);

    twct_pkg::cmd_t    cmd_in;
    logic              keep;
    logic              id_ok;
    logic [CMD_W-1:0]  cmd_raw;

    assign id_ok = (32'(entry_id) < 32'(NUM_ENTRIES));

    // Classify the action and decide whether it reaches the back end
    always_comb
    begin
        cmd_in.entry_id = entry_id;
        cmd_in.delay    = delay;
        cmd_in.kind     = twct_pkg::CMD_TICK;
        keep            = 1'b0;
        unique case (action)
            twct_pkg::ACT_ARM:
            begin
                cmd_in.kind = twct_pkg::CMD_ARM;
                keep        = id_ok;
            end
            twct_pkg::ACT_STOP:
            begin
                cmd_in.kind = twct_pkg::CMD_STOP;
                keep        = id_ok;
            end
            twct_pkg::ACT_TICK:
            begin
                cmd_in.kind = twct_pkg::CMD_TICK;
                keep        = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    twct_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (twct_pkg::CMD_FIFO_DEPTH)
    ) u_cmd_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && keep),
        .wdata (cmd_in),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_raw),
        .empty (cmd_empty)
    );

    assign cmd = twct_pkg::cmd_t'(cmd_raw);

endmodule

>>> sv/twct_back.sv
// ----------------------------------------------------------------------------
// twct_back
// Execution side: arm entries (expiry and a bucket modulo by reciprocal
// multiply), stop entries, and run the per-tick scan over the table, one
// entry per cycle while a full result queue does not stall it, queuing fired
// and overdue results with the last one flagged.
// ----------------------------------------------------------------------------
module twct_back #(
    parameter int NUM_ENTRIES = twct_pkg::NUM_ENTRIES_DEF,
    parameter int NUM_BUCKETS = twct_pkg::NUM_BUCKETS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  twct_pkg::cmd_t      cmd,
    input  logic                cmd_empty,
    output logic                cmd_pop,
    output twct_pkg::result_t   res,
    output logic                res_empty,
    input  logic                res_pop
);

    localparam int IW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int CW    = $clog2(NUM_ENTRIES + 1);
    localparam int BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    localparam int TW    = twct_pkg::TIME_W;
    localparam int MW    = twct_pkg::MOD_CNT_W;
    localparam int RAM_W = TW + BW;
    localparam int RES_W = $bits(twct_pkg::result_t);
    // Reciprocal of the bucket count, rounded up and scaled by 2^RS; the
    // product shifted by RS is the exact quotient of any 32-bit expiry
    localparam int RS    = TW + $clog2(NUM_BUCKETS);
    localparam logic [TW:0]   RECIP     = (TW + 1)'(((64'd1 << RS) + 64'(NUM_BUCKETS)
                                                     - 64'd1) / 64'(NUM_BUCKETS));
    localparam logic [BW-1:0] NB_LOW    = BW'(NUM_BUCKETS);
    localparam logic [BW-1:0] POS_LAST  = BW'(NUM_BUCKETS - 1);
    localparam logic [CW-1:0] IDX_END   = CW'(NUM_ENTRIES);

    twct_pkg::back_state_t state_reg, state_next;

    logic [TW-1:0]          tick_reg, tick_next;
    logic [BW-1:0]          pos_reg, pos_next;
    logic [NUM_ENTRIES-1:0] valid_reg, valid_next;
    logic [TW-1:0]          expiry_reg, expiry_next;
    logic [BW-1:0]          quot_reg, quot_next;
    logic [MW-1:0]          mod_cnt_reg, mod_cnt_next;
    logic [IW-1:0]          arm_id_reg, arm_id_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic                   chk_valid_reg, chk_valid_next;
    logic [IW-1:0]          chk_idx_reg, chk_idx_next;
    logic                   pend_valid_reg, pend_valid_next;
    logic [IW-1:0]          pend_id_reg, pend_id_next;
    logic                   pend_late_reg, pend_late_next;

    logic [2*TW:0]          recip_prod;
    logic [BW-1:0]          quot_mul;
    logic [BW-1:0]          rem_step;
    logic                   ram_we;
    logic [IW-1:0]          ram_raddr;
    logic [RAM_W-1:0]       ram_wdata;
    logic [RAM_W-1:0]       ram_rdata;
    logic [TW-1:0]          rd_expiry;
    logic [BW-1:0]          rd_bucket;
    logic                   issue;
    logic                   hit;
    logic                   late;
    logic                   stall;
    logic                   res_push;
    logic                   res_full;
    twct_pkg::result_t      res_in;
    logic [RES_W-1:0]       res_raw;

    // Bucket modulo: low quotient bits from the reciprocal multiply, then the
    // remainder from the low bits of expiry minus quotient times bucket count
    assign recip_prod = {{(TW + 1){1'b0}}, expiry_reg} * {{TW{1'b0}}, RECIP};
    assign quot_mul   = quot_reg * NB_LOW;
    assign rem_step   = expiry_reg[BW-1:0] - quot_mul;

    // Scan compare on the entry read last cycle
    assign rd_expiry = ram_rdata[RAM_W-1:BW];
    assign rd_bucket = ram_rdata[BW-1:0];
    assign issue     = (idx_reg < IDX_END);
    assign late      = (rd_expiry < tick_reg);
    assign hit       = (state_reg == twct_pkg::B_SCAN) && chk_valid_reg
                       && valid_reg[chk_idx_reg] && (rd_bucket == pos_reg)
                       && (rd_expiry <= tick_reg);
    assign stall     = hit && pend_valid_reg && res_full;

    assign cmd_pop   = (state_reg == twct_pkg::B_IDLE) && !cmd_empty;
    assign ram_we    = (state_reg == twct_pkg::B_MOD) && (mod_cnt_reg == '0);
    assign ram_wdata = {expiry_reg, rem_step};
    assign ram_raddr = stall ? chk_idx_reg : idx_reg[IW-1:0];

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            twct_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.kind)
                        twct_pkg::CMD_ARM:  state_next = twct_pkg::B_MOD;
                        twct_pkg::CMD_TICK: state_next = twct_pkg::B_SCAN;
                        default:            state_next = twct_pkg::B_IDLE;
                    endcase
                end
            end
            twct_pkg::B_MOD:
            begin
                if (mod_cnt_reg == '0)
                begin
                    state_next = twct_pkg::B_IDLE;
                end
            end
            twct_pkg::B_SCAN:
            begin
                if (!issue && !chk_valid_reg)
                begin
                    state_next = twct_pkg::B_LAST;
                end
            end
            twct_pkg::B_LAST:
            begin
                if (!pend_valid_reg || !res_full)
                begin
                    state_next = twct_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = twct_pkg::B_IDLE;
            end
        endcase
    end

    // Datapath and outputs per state
    always_comb
    begin
        tick_next       = tick_reg;
        pos_next        = pos_reg;
        valid_next      = valid_reg;
        expiry_next     = expiry_reg;
        quot_next       = quot_reg;
        mod_cnt_next    = mod_cnt_reg;
        arm_id_next     = arm_id_reg;
        idx_next        = idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_late_next  = pend_late_reg;
        res_push        = 1'b0;
        res_in.fired_entry = twct_pkg::ENTRY_ID_W'(pend_id_reg);
        res_in.overdue     = pend_late_reg;
        res_in.last        = 1'b0;
        unique case (state_reg)
            twct_pkg::B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.kind)
                        twct_pkg::CMD_ARM:
                        begin
                            expiry_next  = tick_reg + TW'(cmd.delay);
                            quot_next    = '0;
                            mod_cnt_next = MW'(1);
                            arm_id_next  = IW'(cmd.entry_id);
                        end
                        twct_pkg::CMD_STOP:
                        begin
                            valid_next[IW'(cmd.entry_id)] = 1'b0;
                        end
                        twct_pkg::CMD_TICK:
                        begin
                            pos_next        = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                            tick_next       = tick_reg + 1'b1;
                            idx_next        = '0;
                            chk_valid_next  = 1'b0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            tick_next = tick_reg;
                        end
                    endcase
                end
            end
            twct_pkg::B_MOD:
            begin
                // Hold the quotient bits, then write expiry and bucket
                quot_next    = recip_prod[RS +: BW];
                mod_cnt_next = mod_cnt_reg - 1'b1;
                if (mod_cnt_reg == '0)
                begin
                    valid_next[arm_id_reg] = 1'b1;
                end
            end
            twct_pkg::B_SCAN:
            begin
                if (!stall)
                begin
                    // Retire the checked entry and advance the read pointer
                    if (hit)
                    begin
                        valid_next[chk_idx_reg] = 1'b0;
                        res_push        = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_id_next    = chk_idx_reg;
                        pend_late_next  = late;
                    end
                    chk_valid_next = issue;
                    chk_idx_next   = idx_reg[IW-1:0];
                    if (issue)
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            twct_pkg::B_LAST:
            begin
                // Flush the held result as the final one of this tick
                res_in.last = 1'b1;
                if (pend_valid_reg && !res_full)
                begin
                    res_push        = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= twct_pkg::B_IDLE;
            tick_reg       <= '0;
            pos_reg        <= '0;
            valid_reg      <= '0;
            idx_reg        <= '0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            mod_cnt_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            tick_reg       <= tick_next;
            pos_reg        <= pos_next;
            valid_reg      <= valid_next;
            idx_reg        <= idx_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            mod_cnt_reg    <= mod_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        expiry_reg    <= expiry_next;
        quot_reg      <= quot_next;
        arm_id_reg    <= arm_id_next;
        chk_idx_reg   <= chk_idx_next;
        pend_id_reg   <= pend_id_next;
        pend_late_reg <= pend_late_next;
    end

    // Expiry and bucket of each entry
    twct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_ENTRIES),
        .AW    (IW)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (arm_id_reg),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Result queue toward the output port
    twct_fifo #(
        .WIDTH (RES_W),
        .DEPTH (twct_pkg::RES_FIFO_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_in),
        .full  (res_full),
        .pop   (res_pop),
        .rdata (res_raw),
        .empty (res_empty)
    );

    assign res = twct_pkg::result_t'(res_raw);

`ifndef SYNTHESIS
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> !res_full)
        else $error("result pushed into a full queue");

    a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.kind == twct_pkg::CMD_TICK) |=> (state_reg == twct_pkg::B_SCAN))
        else $error("tick did not start a scan");

    a_hit_clears_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (hit && !stall) |=> !valid_reg[$past(chk_idx_reg)])
        else $error("expired entry still valid");

    a_tick_advances_once: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_pop && cmd.kind == twct_pkg::CMD_TICK) |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("uptime not advanced by one on tick");
`endif

endmodule

>>> sv/timing_wheel_callout_table_core.sv
// ----------------------------------------------------------------------------
// timing_wheel_callout_table_core
// Hashed timing wheel over a fixed table of timer entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive action/entry_id/delay with push; the item is taken on a
//   clock edge where push is high and full is low. Arm stores an expiry of
//   uptime plus delay, stop clears the entry, tick advances the wheel and
//   scans the table. Unused action codes and entries outside the table are
//   taken and dropped.
//   Result queue: while empty is low, fired_entry/overdue/last show the
//   oldest result; pop takes it. Results of one tick come in ascending entry
//   order, the final one with last set.
//   Back end: a stop is done in the idle state; an arm runs the bucket modulo
//   (a reciprocal multiply, then a subtract) before the entry is written; a
//   tick scans the table through the single read port of the entry RAM, one
//   entry per cycle unless a full result queue stalls it. A two-deep command
//   queue lets items be taken while the back end works.
//   Reset (rst_n low) clears all entries, uptime and wheel position; no
//   clearing pass is needed. When the receiver stops popping, the scan holds
//   once the result queue is full and resumes without loss.
// ----------------------------------------------------------------------------
module timing_wheel_callout_table_core #(
    parameter int NUM_ENTRIES = twct_pkg::NUM_ENTRIES_DEF,
    parameter int NUM_BUCKETS = twct_pkg::NUM_BUCKETS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [twct_pkg::ACTION_W-1:0]       action,
    input  logic [twct_pkg::ENTRY_ID_W-1:0]     entry_id,
    input  logic [twct_pkg::DELAY_W-1:0]        delay,
    output logic                                empty,
    input  logic                                pop,
    output logic [twct_pkg::ENTRY_ID_W-1:0]     fired_entry,
    output logic                                overdue,
    output logic                                last
);

    twct_pkg::cmd_t    cmd;
    logic              cmd_empty;
    logic              cmd_pop;
    twct_pkg::result_t res;

    twct_front #(
        .NUM_ENTRIES (NUM_ENTRIES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .action    (action),
        .entry_id  (entry_id),
        .delay     (delay),
        .full      (full),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop)
    );

    twct_back #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .NUM_BUCKETS (NUM_BUCKETS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .res       (res),
        .res_empty (empty),
        .res_pop   (pop)
    );

    // Split the head result onto its ports
    assign fired_entry = res.fired_entry;
    assign overdue     = res.overdue;
    assign last        = res.last;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for timing_wheel_callout_table_core. Sends arm, stop,
// tick and unused items through the input queue, predicts fired and overdue
// results with a local timing wheel model, and checks every popped result
// in order. Both sides idle in random bursts, and the receiver holds off
// long enough once to back the block up to its input.
// ----------------------------------------------------------------------------
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_ENTRIES   = twct_pkg::NUM_ENTRIES_DEF;
    localparam int N_BUCKETS   = twct_pkg::NUM_BUCKETS_DEF;
    localparam int AW          = twct_pkg::ACTION_W;
    localparam int EW          = twct_pkg::ENTRY_ID_W;
    localparam int DW          = twct_pkg::DELAY_W;
    localparam int TW          = twct_pkg::TIME_W;
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 100;

    // Action code that the block takes and drops
    localparam logic [AW-1:0] ACT_UNUSED = 2'd3;

    logic          clk;
    logic          rst_n;
    logic          push;
    logic          full;
    logic [AW-1:0] action;
    logic [EW-1:0] entry_id;
    logic [DW-1:0] delay;
    logic          empty;
    logic          pop;
    logic [EW-1:0] fired_entry;
    logic          overdue;
    logic          last;

    // Local copy of the timer table and wheel
    logic          wheel_valid  [N_ENTRIES];
    logic [TW-1:0] wheel_expiry [N_ENTRIES];
    logic [2:0]    wheel_bucket [N_ENTRIES];
    logic [2:0]    wheel_pos;
    logic [TW-1:0] uptime;

    twct_pkg::result_t pending_callouts[$];
    int                error_count;
    int                cycle_count;
    bit                idle_on;
    int                hold_req_count;
    int                hold_done_count;

    timing_wheel_callout_table_core #(
        .NUM_ENTRIES (N_ENTRIES),
        .NUM_BUCKETS (N_BUCKETS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .action      (action),
        .entry_id    (entry_id),
        .delay       (delay),
        .empty       (empty),
        .pop         (pop),
        .fired_entry (fired_entry),
        .overdue     (overdue),
        .last        (last)
    );

    // Toggle the clock every half period
    always #4 clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Update the timer table for one accepted item and queue its callouts
    function automatic void predict_callouts(
        input logic [AW-1:0] act,
        input logic [EW-1:0] id,
        input logic [DW-1:0] dly
    );
        logic [TW-1:0]     expiry;
        twct_pkg::result_t hits[$];
        twct_pkg::result_t hit;
        logic              late;
        case (act)
            twct_pkg::ACT_ARM:
            begin
                expiry           = uptime + TW'(dly);
                wheel_expiry[id] = expiry;
                wheel_bucket[id] = 3'(expiry % N_BUCKETS);
                wheel_valid[id]  = 1'b1;
            end
            twct_pkg::ACT_STOP:
            begin
                wheel_valid[id] = 1'b0;
            end
            twct_pkg::ACT_TICK:
            begin
                wheel_pos = 3'((wheel_pos + 1) % N_BUCKETS);
                uptime    = uptime + 1;
                for (int i = 0; i < N_ENTRIES; i++)
                begin
                    if (!wheel_valid[i] || wheel_bucket[i] != wheel_pos)
                        continue;
                    late = wheel_expiry[i] < uptime;
                    if (wheel_expiry[i] != uptime && !late)
                        continue;
                    wheel_valid[i]  = 1'b0;
                    hit.fired_entry = EW'(i);
                    hit.overdue     = late;
                    hit.last        = 1'b0;
                    hits.push_back(hit);
                end
                if (hits.size() > 0)
                    hits[hits.size() - 1].last = 1'b1;
                foreach (hits[k])
                    pending_callouts.push_back(hits[k]);
            end
            default:
            begin
                // drop unused codes
            end
        endcase
    endfunction

    // Offer one item, with an occasional idle burst first, and wait for it
    task automatic send_item(
        input logic [AW-1:0] act,
        input logic [EW-1:0] id,
        input logic [DW-1:0] dly
    );
        int gap;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push     <= 1'b1;
        action   <= act;
        entry_id <= id;
        delay    <= dly;
        do
            @(posedge clk);
        while (full);
        predict_callouts(act, id, dly);
    endtask

    // Drop push and wait for every queued callout to come out
    task automatic drain();
        @(negedge clk);
        push <= 1'b0;
        wait (pending_callouts.size() == 0);
    endtask

    // Pop results, idling in bursts and holding off when asked
    initial
    begin : receiver
        int stall;
        pop = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req_count != hold_done_count)
            begin
                hold_done_count++;
                pop <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(1, 12);
                pop <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // Check each popped result against the oldest queued callout
    always @(posedge clk)
    begin : result_check
        twct_pkg::result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_callouts.size() == 0)
            begin
                $error("unexpected result: fired_entry %0d overdue %0d last %0d",
                       fired_entry, overdue, last);
                error_count++;
            end
            else
            begin
                want = pending_callouts.pop_front();
                if (fired_entry !== want.fired_entry)
                begin
                    $error("fired_entry: expected %0d, got %0d",
                           want.fired_entry, fired_entry);
                    error_count++;
                end
                if (overdue !== want.overdue)
                begin
                    $error("overdue: expected %0d, got %0d", want.overdue, overdue);
                    error_count++;
                end
                if (last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, last);
                    error_count++;
                end
            end
        end
    end

    // Field extremes, re-arm, stop of an idle entry, unused code, empty tick
    task automatic test_directed();
        send_item(twct_pkg::ACT_TICK, 4'd0, 16'd0);
        send_item(twct_pkg::ACT_ARM, 4'd0, 16'd1);
        send_item(twct_pkg::ACT_ARM, 4'd15, 16'd0);
        send_item(twct_pkg::ACT_ARM, 4'd2, 16'd2);
        send_item(twct_pkg::ACT_ARM, 4'd2, 16'd3);
        send_item(twct_pkg::ACT_ARM, 4'd9, 16'hFFFF);
        send_item(twct_pkg::ACT_ARM, 4'd10, 16'h5555);
        send_item(twct_pkg::ACT_ARM, 4'd11, 16'hAAAA);
        send_item(twct_pkg::ACT_STOP, 4'd9, 16'd0);
        send_item(twct_pkg::ACT_STOP, 4'd7, 16'd0);
        send_item(twct_pkg::ACT_STOP, 4'd11, 16'hFFFF);
        send_item(ACT_UNUSED, 4'd1, 16'hFFFF);
        repeat (5) send_item(twct_pkg::ACT_TICK, 4'd15, 16'hFFFF);
        drain();
    endtask

    // Fill one bucket with overdue and due entries, then hold off the receiver
    task automatic test_backpressure();
        for (int i = 0; i < N_ENTRIES / 2; i++)
            send_item(twct_pkg::ACT_ARM, EW'(i), 16'd0);
        for (int i = N_ENTRIES / 2; i < N_ENTRIES; i++)
            send_item(twct_pkg::ACT_ARM, EW'(i), 16'd5);
        hold_req_count++;
        repeat (5) send_item(twct_pkg::ACT_TICK, 4'd0, 16'd0);
        for (int i = 0; i < 6; i++)
            send_item(twct_pkg::ACT_ARM, EW'(i), DW'(i + 1));
        repeat (7) send_item(twct_pkg::ACT_TICK, 4'd0, 16'd0);
        drain();
    endtask

    // Random mix, weighted toward short timers so that many expire
    task automatic test_random(input int count);
        int            pick;
        logic [AW-1:0] act;
        logic [DW-1:0] dly;
        logic [EW-1:0] id;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            id   = EW'($urandom_range(0, N_ENTRIES - 1));
            dly  = DW'($urandom_range(0, 12));
            if (pick < 40)
                act = twct_pkg::ACT_ARM;
            else if (pick < 45)
            begin
                act = twct_pkg::ACT_ARM;
                dly = DW'($urandom_range(0, 65535));
            end
            else if (pick < 58)
                act = twct_pkg::ACT_STOP;
            else if (pick < 97)
                act = twct_pkg::ACT_TICK;
            else
            begin
                act = ACT_UNUSED;
                dly = DW'($urandom_range(0, 65535));
            end
            send_item(act, id, dly);
        end
        drain();
    endtask

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        push            = 1'b0;
        action          = twct_pkg::ACT_ARM;
        entry_id        = '0;
        delay           = '0;
        error_count     = 0;
        cycle_count     = 0;
        idle_on         = 1'b1;
        hold_req_count  = 0;
        hold_done_count = 0;
        wheel_pos       = '0;
        uptime          = '0;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            wheel_valid[i]  = 1'b0;
            wheel_expiry[i] = '0;
            wheel_bucket[i] = '0;
        end
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_backpressure();
        test_random(150);
        idle_on = 1'b0;
        test_random(80);

        // Let the back end finish any trailing arm or tick
        repeat (SETTLE) @(posedge clk);
        if (pending_callouts.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_callouts.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
